/* design/assert_macros.svh */
// Assertion macros shared by the checker files.
// No dependencies; included by name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is active.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/twpc_pkg.sv */
// Shared types and constants of the time window peak counter.
// No dependencies; imported by the controller, datapath and top level.
package twpc_pkg;

	localparam int unsigned TIME_W  = 32;
	localparam int unsigned COUNT_W = 11;
	localparam logic [TIME_W-1:0] WINDOW_LENGTH_RESET = 32'd60;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_FETCH,
		S_DRAIN
	} state_t;

	typedef struct packed {
		logic cfg_wr;
		logic load;
		logic pop;
		logic push;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic pop_ok;
		logic occ_zero;
		logic last;
	} sts_t;

endpackage

/* design/twpc_ctrl.sv */
// Sequencer of the time window peak counter: handshakes and datapath commands.
// Depends on twpc_pkg.
module twpc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	output logic           out_valid,
	input  logic           out_stall,
	input  twpc_pkg::sts_t sts,
	output twpc_pkg::cmd_t cmd
);
	import twpc_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		cfg_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_stall   = 1'b0;
				cfg_ready  = 1'b1;
				cmd.cfg_wr = cfg_valid;
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = S_CMP;
				end
			end
			S_CMP: begin
				if (sts.pop_ok) begin
					cmd.pop = 1'b1;
				end else begin
					cmd.push  = 1'b1;
					state_nxt = sts.last ? S_FETCH : S_IDLE;
				end
			end
			S_FETCH: begin
				state_nxt = S_DRAIN;
			end
			S_DRAIN: begin
				if (!sts.occ_zero) begin
					cmd.pop = 1'b1;
				end else if (!out_valid_q || !out_stall) begin
					cmd.emit  = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

/* design/twpc_dp.sv */
// Datapath of the time window peak counter: timestamp ring, occupancy, best window.
// Depends on twpc_pkg.
module twpc_dp #(
	parameter int unsigned WINDOW_DEPTH = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  twpc_pkg::cmd_t                 cmd,
	output twpc_pkg::sts_t                 sts,
	input  logic [twpc_pkg::TIME_W-1:0]    cfg_data,
	input  logic [twpc_pkg::TIME_W-1:0]    event_time,
	input  logic                           last_event,
	output logic [twpc_pkg::COUNT_W-1:0]   peak_count,
	output logic [twpc_pkg::TIME_W-1:0]    peak_start,
	output logic [twpc_pkg::TIME_W-1:0]    peak_end,
	output logic                           overflowed
);
	import twpc_pkg::*;

	localparam int unsigned PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int unsigned OCC_W = $clog2(WINDOW_DEPTH + 1);
	localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(WINDOW_DEPTH);
	localparam logic [OCC_W:0]   SUM_WRAP = (OCC_W + 1)'(WINDOW_DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_DEPTH - 1);

	logic [TIME_W-1:0]  ring_mem [WINDOW_DEPTH];
	logic [TIME_W-1:0]  rd_data_q;
	logic [TIME_W-1:0]  len_q;
	logic [TIME_W-1:0]  now_q;
	logic               last_q;
	logic [PTR_W-1:0]   head_q;
	logic [OCC_W-1:0]   occ_q;
	logic [OCC_W-1:0]   best_count_q;
	logic [TIME_W-1:0]  best_start_q;
	logic               ovf_q;
	logic [COUNT_W-1:0] peak_count_q;
	logic [TIME_W-1:0]  peak_start_q;
	logic [TIME_W-1:0]  peak_end_q;
	logic               overflowed_q;

	logic [PTR_W-1:0]   head_inc;
	logic [PTR_W-1:0]   rd_addr;
	logic [OCC_W:0]     wr_sum;
	logic [OCC_W:0]     wr_wrap;
	logic [PTR_W-1:0]   wr_addr;
	logic [TIME_W:0]    front_end;

	assign head_inc  = (head_q == PTR_LAST) ? '0 : head_q + PTR_W'(1);
	assign rd_addr   = cmd.pop ? head_inc : head_q;
	assign wr_sum    = (OCC_W + 1)'(head_q) + {1'b0, occ_q};
	assign wr_wrap   = (wr_sum >= SUM_WRAP) ? wr_sum - SUM_WRAP : wr_sum;
	assign wr_addr   = wr_wrap[PTR_W-1:0];
	assign front_end = {1'b0, rd_data_q} + {1'b0, len_q};

	assign sts.pop_ok   = (occ_q != '0) && ({1'b0, now_q} > front_end);
	assign sts.occ_zero = (occ_q == '0);
	assign sts.last     = last_q;

	// ring storage, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.push && (occ_q != OCC_FULL)) begin
			ring_mem[wr_addr] <= now_q;
		end
		rd_data_q <= ring_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			now_q <= event_time;
		end
		if (cmd.emit) begin
			peak_count_q <= COUNT_W'(best_count_q);
			peak_start_q <= best_start_q;
			peak_end_q   <= best_start_q + len_q;
			overflowed_q <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q        <= WINDOW_LENGTH_RESET;
			last_q       <= 1'b0;
			head_q       <= '0;
			occ_q        <= '0;
			best_count_q <= '0;
			best_start_q <= '0;
			ovf_q        <= 1'b0;
		end else begin
			if (cmd.cfg_wr) begin
				len_q <= cfg_data;
			end
			if (cmd.load) begin
				last_q <= last_event;
			end
			if (cmd.pop) begin
				if (occ_q > best_count_q) begin
					best_count_q <= occ_q;
					best_start_q <= rd_data_q;
				end
				head_q <= head_inc;
				occ_q  <= occ_q - OCC_W'(1);
			end
			if (cmd.push) begin
				if (occ_q == OCC_FULL) begin
					ovf_q <= 1'b1;
				end else begin
					occ_q <= occ_q + OCC_W'(1);
				end
			end
			if (cmd.emit) begin
				head_q       <= '0;
				occ_q        <= '0;
				best_count_q <= '0;
				best_start_q <= '0;
				ovf_q        <= 1'b0;
			end
		end
	end

	assign peak_count = peak_count_q;
	assign peak_start = peak_start_q;
	assign peak_end   = peak_end_q;
	assign overflowed = overflowed_q;

endmodule

/* design/time_window_peak_count_top.sv */
// Top level of the time window peak counter: controller plus datapath.
// Depends on twpc_pkg, twpc_ctrl and twpc_dp.
//
//   channel  handshake            payload
//   in       in_valid / in_stall  event_time, last_event
//   cfg      cfg_valid/cfg_ready  cfg_data (window_length)
//   out      out_valid/out_stall  peak_count, peak_start, peak_end, overflowed
//
// An event pops a timestamp per window it closes (one ring read per pop).
// A last event then pops every held timestamp, then the result loads.
// The result register frees the input side; a new event is taken while it waits.
// Reset clears control state and sets window_length to 60; the ring needs no clear.
// cfg_ready is high only between events.
module time_window_peak_count_top #(
	parameter int unsigned WINDOW_DEPTH = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [twpc_pkg::TIME_W-1:0]   event_time,
	input  logic                          last_event,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [twpc_pkg::TIME_W-1:0]   cfg_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [twpc_pkg::COUNT_W-1:0]  peak_count,
	output logic [twpc_pkg::TIME_W-1:0]   peak_start,
	output logic [twpc_pkg::TIME_W-1:0]   peak_end,
	output logic                          overflowed
);
	import twpc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	twpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	twpc_dp #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_data   (cfg_data),
		.event_time (event_time),
		.last_event (last_event),
		.peak_count (peak_count),
		.peak_start (peak_start),
		.peak_end   (peak_end),
		.overflowed (overflowed)
	);

endmodule

/* design/twpc_check.sv */
// Port-level checks of the time window peak counter, bound to the top level.
// Depends on twpc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module twpc_check (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          cfg_ready,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [twpc_pkg::COUNT_W-1:0]  peak_count,
	input logic [twpc_pkg::TIME_W-1:0]   peak_start,
	input logic [twpc_pkg::TIME_W-1:0]   peak_end,
	input logic                          overflowed
);
	import twpc_pkg::*;

	logic [COUNT_W+2*TIME_W:0] out_bus;

	assign out_bus = {peak_count, peak_start, peak_end, overflowed};

	`ASSERT_CLK(a_busy_after_accept, in_valid && !in_stall |=> in_stall, "no stall after accept")
	`ASSERT_ALWAYS(a_cfg_only_idle, cfg_ready == !in_stall, "cfg ready outside idle")
	`ASSERT_CLK(a_result_while_busy, $rose(out_valid) |-> $past(in_stall), "result while idle")
	`ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid, "stalled result dropped")
	`ASSERT_CLK(a_out_stable, out_valid && out_stall |=> $stable(out_bus), "stalled result changed")

endmodule

bind time_window_peak_count_top twpc_check u_check (.*);
